[sv/sky_region_membership_border_distance_assert.svh]
// Assertion macros for the sky region membership RTL.
`ifndef SKY_REGION_MEMBERSHIP_BORDER_DISTANCE_ASSERT_SVH
`define SKY_REGION_MEMBERSHIP_BORDER_DISTANCE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SRMBD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define SRMBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/srmbd_pkg.sv]
// Types, constants and cosine table for the sky region membership block.
package srmbd_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int COS_TABLE_DEPTH = 721;

    localparam int UNIT    = 1 << ANGLE_FRAC_BITS;
    localparam int FULL    = 360 * UNIT;
    localparam int HALF    = 180 * UNIT;
    localparam int QUARTER = 90 * UNIT;

    // 1000 * x > UNIT  <=>  x > POLE_TOL for integer x
    localparam int POLE_TOL = UNIT / 1000;
    // 10 * span < UNIT  <=>  span <= RING_MAX
    localparam int RING_MAX = (UNIT - 1) / 10;

    localparam int LON_W  = 19;
    localparam int LAT_W  = 16;
    localparam int EDGE_W = 17;
    localparam int DIST_W = 17;
    localparam int GAP_W  = $clog2(HALF + 1);
    localparam int COS_W  = 16;
    localparam int PROD_W = GAP_W + COS_W;
    localparam int IDX_W  = $clog2(COS_TABLE_DEPTH);
    localparam int COS_LAST = COS_TABLE_DEPTH - 1;
    // table step is a power-of-two number of angle units
    localparam int COS_IDX_SHIFT = $clog2(QUARTER / COS_LAST);

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_LON_START = 2'd0;
    localparam logic [1:0] REG_LON_END   = 2'd1;
    localparam logic [1:0] REG_LAT_LOW   = 2'd2;
    localparam logic [1:0] REG_LAT_HIGH  = 2'd3;

    typedef logic [COS_W-1:0] cos_tab_t [COS_TABLE_DEPTH];

    function automatic cos_tab_t build_cos_tab();
        cos_tab_t t;
        real ang;
        real v;
        for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
            ang  = (3.141592653589793 / 2.0) * i / COS_LAST;
            v    = $cos(ang) * 65535.0 + 0.5;
            t[i] = COS_W'($rtoi(v));
        end
        return t;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

    typedef struct packed {
        logic [EDGE_W-1:0]       lon_start;
        logic [EDGE_W-1:0]       lon_end;
        logic signed [LAT_W-1:0] lat_low;
        logic signed [LAT_W-1:0] lat_high;
        logic                    ring;
        logic                    wrap;
        logic                    lo_edge_en;
        logic                    hi_edge_en;
    } cfg_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    typedef struct packed {
        logic                     in_region;
        logic signed [DIST_W-1:0] dlat;
        logic [GAP_W-1:0]         gap_s;
        logic [GAP_W-1:0]         gap_e;
        logic [COS_W-1:0]         cosv;
    } front_t;

endpackage

[sv/sky_region_membership_border_distance.sv]
// Sky region membership and border distance, top level with pipeline control.
// Takes one point per cycle unless the output stalls and returns its inside flag
// and signed border distance through four register stages: stage one wraps the
// longitude and forms the latitude margins,
// stage two reads the COS_TABLE_DEPTH-entry cosine ROM and folds both edge gaps, stage three
// multiplies both gaps by the cosine, stage four takes the minimum into the output
// register. Each stage stalls only when the one after it is full, so bubbles close
// up and points keep entering while a result waits on m_ready. The user must write
// the APB region registers only while no point is in flight; nothing enforces it.
`include "sky_region_membership_border_distance_assert.svh"

module sky_region_membership_border_distance (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [srmbd_pkg::LON_W-1:0]  s_point_lon,
    input  logic signed [srmbd_pkg::LAT_W-1:0]  s_point_lat,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_is_inside,
    output logic signed [srmbd_pkg::DIST_W-1:0] m_edge_distance,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srmbd_pkg::ADDR_W-1:0]        paddr,
    input  logic [srmbd_pkg::DATA_W-1:0]        pwdata,
    output logic [srmbd_pkg::DATA_W-1:0]        prdata,
    output logic                                pready
);

    srmbd_pkg::cfg_t      cfg;
    srmbd_pkg::stage_en_t en;
    srmbd_pkg::front_t    fr;

    logic [3:0] vld_reg, vld_next;
    logic [3:0] rdy;

    always_comb begin
        rdy[3] = !vld_reg[3] || m_ready;
        for (int k = 2; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
        vld_next[0] = rdy[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < 4; k++)
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        en.s1 = rdy[0];
        en.s2 = rdy[1];
        en.s3 = rdy[2];
        en.s4 = rdy[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign s_ready = rdy[0];
    assign m_valid = vld_reg[3];

    srmbd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    srmbd_front u_front (
        .aclk      (aclk),
        .cfg       (cfg),
        .en        (en),
        .point_lon (s_point_lon),
        .point_lat (s_point_lat),
        .fr        (fr)
    );

    srmbd_back u_back (
        .aclk          (aclk),
        .cfg           (cfg),
        .en            (en),
        .fr            (fr),
        .is_inside     (m_is_inside),
        .edge_distance (m_edge_distance)
    );

    // back-pressure only once every stage holds a beat
    `SRMBD_ASSERT_IMPL(a_full_stall, aclk, aresetn, !s_ready, &vld_reg, "stall with a bubble")
    `SRMBD_ASSERT_NEXT(a_enter, aclk, aresetn, s_valid && s_ready, vld_reg[0], "beat lost at entry")
    `SRMBD_ASSERT_IMPL(a_dist_max, aclk, aresetn, m_valid, m_edge_distance <= srmbd_pkg::HALF, "distance above half turn")

endmodule

[sv/srmbd_cfg.sv]
// APB register file and derived region flags.
module srmbd_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srmbd_pkg::ADDR_W-1:0]  paddr,
    input  logic [srmbd_pkg::DATA_W-1:0]  pwdata,
    output logic [srmbd_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output srmbd_pkg::cfg_t               cfg
);

    logic [srmbd_pkg::EDGE_W-1:0]       lon_start_reg;
    logic [srmbd_pkg::EDGE_W-1:0]       lon_end_reg;
    logic signed [srmbd_pkg::LAT_W-1:0] lat_low_reg;
    logic signed [srmbd_pkg::LAT_W-1:0] lat_high_reg;
    logic [1:0]                         idx;
    logic                               wr;
    logic [srmbd_pkg::EDGE_W-1:0]       span;
    logic signed [srmbd_pkg::LAT_W+1:0] lo_q;
    logic signed [srmbd_pkg::LAT_W+1:0] hi_q;

    assign idx    = paddr[3:2];
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lon_start_reg <= '0;
            lon_end_reg   <= '0;
            lat_low_reg   <= srmbd_pkg::LAT_W'(-srmbd_pkg::QUARTER);
            lat_high_reg  <= srmbd_pkg::LAT_W'(srmbd_pkg::QUARTER);
        end else if (wr) begin
            case (idx)
                srmbd_pkg::REG_LON_START: lon_start_reg <= pwdata[srmbd_pkg::EDGE_W-1:0];
                srmbd_pkg::REG_LON_END:   lon_end_reg   <= pwdata[srmbd_pkg::EDGE_W-1:0];
                srmbd_pkg::REG_LAT_LOW:   lat_low_reg   <= pwdata[srmbd_pkg::LAT_W-1:0];
                srmbd_pkg::REG_LAT_HIGH:  lat_high_reg  <= pwdata[srmbd_pkg::LAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            srmbd_pkg::REG_LON_START:
                prdata = {{(srmbd_pkg::DATA_W-srmbd_pkg::EDGE_W){1'b0}}, lon_start_reg};
            srmbd_pkg::REG_LON_END:
                prdata = {{(srmbd_pkg::DATA_W-srmbd_pkg::EDGE_W){1'b0}}, lon_end_reg};
            srmbd_pkg::REG_LAT_LOW:
                prdata = {{(srmbd_pkg::DATA_W-srmbd_pkg::LAT_W){1'b0}}, lat_low_reg};
            srmbd_pkg::REG_LAT_HIGH:
                prdata = {{(srmbd_pkg::DATA_W-srmbd_pkg::LAT_W){1'b0}}, lat_high_reg};
            default:
                prdata = '0;
        endcase
    end

    always_comb begin
        span = (lon_start_reg > lon_end_reg) ? lon_start_reg - lon_end_reg
                                             : lon_end_reg - lon_start_reg;
        lo_q = (srmbd_pkg::LAT_W+2)'(lat_low_reg) + (srmbd_pkg::LAT_W+2)'(srmbd_pkg::QUARTER);
        hi_q = (srmbd_pkg::LAT_W+2)'(srmbd_pkg::QUARTER) - (srmbd_pkg::LAT_W+2)'(lat_high_reg);
        cfg.lon_start  = lon_start_reg;
        cfg.lon_end    = lon_end_reg;
        cfg.lat_low    = lat_low_reg;
        cfg.lat_high   = lat_high_reg;
        cfg.ring       = (span <= srmbd_pkg::EDGE_W'(srmbd_pkg::RING_MAX));
        cfg.wrap       = (lon_start_reg > lon_end_reg);
        cfg.lo_edge_en = (lo_q > srmbd_pkg::POLE_TOL);
        cfg.hi_edge_en = (hi_q > srmbd_pkg::POLE_TOL);
    end

endmodule

[sv/srmbd_front.sv]
// Stages one and two: longitude wrap, latitude margins, cosine lookup, edge gaps.
module srmbd_front (
    input  logic                               aclk,
    input  srmbd_pkg::cfg_t                    cfg,
    input  srmbd_pkg::stage_en_t               en,
    input  logic signed [srmbd_pkg::LON_W-1:0] point_lon,
    input  logic signed [srmbd_pkg::LAT_W-1:0] point_lat,
    output srmbd_pkg::front_t                  fr
);

    localparam int LW = srmbd_pkg::LON_W;
    localparam int AW = srmbd_pkg::LAT_W + 1;

    // stage one
    logic signed [LW-1:0]                  lon_reg, lon_next;
    logic [srmbd_pkg::IDX_W-1:0]           idx_reg, idx_next;
    logic                                  lat_ok_reg, lat_ok_next;
    logic signed [srmbd_pkg::DIST_W-1:0]   dlat_reg, dlat_next;

    // stage two
    srmbd_pkg::front_t                     fr_reg, fr_next;

    logic signed [LW:0]                    lon_x;
    logic [AW-1:0]                         alat;
    logic [AW-1:0]                         idx_raw;
    logic signed [srmbd_pkg::DIST_W-1:0]   m_lo;
    logic signed [srmbd_pkg::DIST_W-1:0]   m_hi;
    logic signed [LW:0]                    lon_c;
    logic                                  lon_in;

    function automatic logic [srmbd_pkg::GAP_W-1:0] fold_gap(
        input logic signed [LW-1:0]            lon,
        input logic [srmbd_pkg::EDGE_W-1:0]    edg
    );
        logic signed [LW:0] g;
        logic signed [LW:0] f;
        g = (LW+1)'(lon) - $signed({1'b0, edg});
        if (g < 0)
            g = -g;
        f = g;
        if (g > srmbd_pkg::HALF)
            f = (LW+1)'(srmbd_pkg::FULL) - g;
        if (f < 0)
            f = '0;
        return srmbd_pkg::GAP_W'(f);
    endfunction

    always_comb begin
        lon_x = (LW+1)'(point_lon);
        if (lon_x < 0)
            lon_x = lon_x + (LW+1)'(srmbd_pkg::FULL);
        else if (lon_x >= srmbd_pkg::FULL)
            lon_x = lon_x - (LW+1)'(srmbd_pkg::FULL);
        lon_next = lon_x[LW-1:0];

        alat    = point_lat[srmbd_pkg::LAT_W-1] ? AW'(-AW'(point_lat)) : AW'(point_lat);
        idx_raw = alat >> srmbd_pkg::COS_IDX_SHIFT;
        if (idx_raw > AW'(srmbd_pkg::COS_LAST))
            idx_next = srmbd_pkg::IDX_W'(srmbd_pkg::COS_LAST);
        else
            idx_next = idx_raw[srmbd_pkg::IDX_W-1:0];

        lat_ok_next = (point_lat >= cfg.lat_low) && (point_lat <= cfg.lat_high);

        m_lo = srmbd_pkg::DIST_W'(point_lat) - srmbd_pkg::DIST_W'(cfg.lat_low);
        m_hi = srmbd_pkg::DIST_W'(cfg.lat_high) - srmbd_pkg::DIST_W'(point_lat);
        dlat_next = srmbd_pkg::DIST_W'(srmbd_pkg::HALF);
        if (cfg.lo_edge_en && m_lo < dlat_next)
            dlat_next = m_lo;
        if (cfg.hi_edge_en && m_hi < dlat_next)
            dlat_next = m_hi;
    end

    always_comb begin
        lon_c = (LW+1)'(lon_reg);
        if (cfg.wrap)
            lon_in = (lon_c >= $signed({1'b0, cfg.lon_start}))
                  || (lon_c <= $signed({1'b0, cfg.lon_end}));
        else
            lon_in = (lon_c >= $signed({1'b0, cfg.lon_start}))
                  && (lon_c <= $signed({1'b0, cfg.lon_end}));
        fr_next.in_region = lat_ok_reg && (cfg.ring || lon_in);
        fr_next.dlat      = dlat_reg;
        fr_next.gap_s     = fold_gap(lon_reg, cfg.lon_start);
        fr_next.gap_e     = fold_gap(lon_reg, cfg.lon_end);
        fr_next.cosv      = '0;
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            lon_reg    <= lon_next;
            idx_reg    <= idx_next;
            lat_ok_reg <= lat_ok_next;
            dlat_reg   <= dlat_next;
        end
        if (en.s2) begin
            fr_reg.in_region <= fr_next.in_region;
            fr_reg.dlat      <= fr_next.dlat;
            fr_reg.gap_s     <= fr_next.gap_s;
            fr_reg.gap_e     <= fr_next.gap_e;
            // registered ROM read
            fr_reg.cosv      <= srmbd_pkg::COS_TAB[idx_reg];
        end
    end

    assign fr = fr_reg;

endmodule

[sv/srmbd_back.sv]
// Stages three and four: cosine scaling of the edge gaps and the final minimum.
module srmbd_back (
    input  logic                                aclk,
    input  srmbd_pkg::cfg_t                     cfg,
    input  srmbd_pkg::stage_en_t                en,
    input  srmbd_pkg::front_t                   fr,
    output logic                                is_inside,
    output logic signed [srmbd_pkg::DIST_W-1:0] edge_distance
);

    logic [srmbd_pkg::PROD_W-1:0]          prod_s_reg, prod_s_next;
    logic [srmbd_pkg::PROD_W-1:0]          prod_e_reg, prod_e_next;
    logic                                  inside3_reg;
    logic signed [srmbd_pkg::DIST_W-1:0]   dlat3_reg;

    logic                                  inside_reg;
    logic signed [srmbd_pkg::DIST_W-1:0]   dist_reg, dist_next;

    logic signed [srmbd_pkg::DIST_W-1:0]   ps;
    logic signed [srmbd_pkg::DIST_W-1:0]   pe;

    assign prod_s_next = srmbd_pkg::PROD_W'(fr.gap_s) * srmbd_pkg::PROD_W'(fr.cosv);
    assign prod_e_next = srmbd_pkg::PROD_W'(fr.gap_e) * srmbd_pkg::PROD_W'(fr.cosv);

    always_comb begin
        ps = $signed({1'b0, prod_s_reg[srmbd_pkg::PROD_W-1:srmbd_pkg::COS_W]});
        pe = $signed({1'b0, prod_e_reg[srmbd_pkg::PROD_W-1:srmbd_pkg::COS_W]});
        dist_next = dlat3_reg;
        if (!cfg.ring) begin
            if (ps < dist_next)
                dist_next = ps;
            if (pe < dist_next)
                dist_next = pe;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            prod_s_reg  <= prod_s_next;
            prod_e_reg  <= prod_e_next;
            inside3_reg <= fr.in_region;
            dlat3_reg   <= fr.dlat;
        end
        if (en.s4) begin
            inside_reg <= inside3_reg;
            dist_reg   <= dist_next;
        end
    end

    assign is_inside     = inside_reg;
    assign edge_distance = dist_reg;

endmodule

[bench/sky_region_membership_border_distance_tb.sv]
// Testbench for the sky region membership and border distance block.
module sky_region_membership_border_distance_tb;
    import srmbd_pkg::*;

    localparam int N_FIXED     = 6;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 93;
    localparam int LIMIT       = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int N_DIR       = 12;
    localparam int LON_MIN     = -92160;
    localparam int LON_MAX     = 184319;

    localparam int FIX_START [N_FIXED] = '{0, 92159, 1000, 1000, 46080, 30000};
    localparam int FIX_END   [N_FIXED] = '{92159, 0, 1025, 1026, 46080, 60000};
    localparam int FIX_LO    [N_FIXED] = '{-23040, -23039, -3000, -23040, 23040, 0};
    localparam int FIX_HI    [N_FIXED] = '{23040, 23039, 4000, 0, -23040, 0};

    localparam int DIR_LON [N_DIR] = '{-92160, 184319, 0, 92159, -1, 92160,
                                       80000, 10000, -12160, 91000, 20000, 50000};
    localparam int DIR_LAT [N_DIR] = '{-23040, 23040, 0, 0, 100, -100,
                                       -5000, 7000, 0, 0, -23040, 23040};

    typedef struct packed {
        logic signed [LON_W-1:0] lon;
        logic signed [LAT_W-1:0] lat;
    } point_t;

    typedef struct packed {
        logic                     in_region;
        logic signed [DIST_W-1:0] edge_dist;
    } verdict_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic signed [LON_W-1:0]     s_point_lon;
    logic signed [LAT_W-1:0]     s_point_lat;
    logic                        m_valid;
    logic                        m_ready;
    logic                        m_is_inside;
    logic signed [DIST_W-1:0]    m_edge_distance;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ADDR_W-1:0]           paddr;
    logic [DATA_W-1:0]           pwdata;
    logic [DATA_W-1:0]           prdata;
    logic                        pready;

    logic [EDGE_W-1:0]       cfg_lon_start;
    logic [EDGE_W-1:0]       cfg_lon_end;
    logic signed [LAT_W-1:0] cfg_lat_low;
    logic signed [LAT_W-1:0] cfg_lat_high;
    int                      cos_q16 [COS_TABLE_DEPTH];

    point_t   pending_points [$];
    verdict_t expected_verdicts [$];

    bit in_fire;
    bit out_fire;
    bit in_idle_on;
    bit out_idle_on;
    bit long_hold_req;
    int in_gap;
    int out_gap;
    int hold_left;
    int cycles;
    int mismatches;

    sky_region_membership_border_distance dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_point_lon     (s_point_lon),
        .s_point_lat     (s_point_lat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_inside     (m_is_inside),
        .m_edge_distance (m_edge_distance),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint folded_gap(longint lon, longint edge_at);
        longint g;
        g = lon - edge_at;
        if (g < 0) g = -g;
        if (g > HALF) g = FULL - g;
        if (g < 0) g = 0;
        return g;
    endfunction

    function automatic verdict_t region_verdict(point_t pt);
        longint   lon, lat, lo, hi, s, e, span, best, alat, idx, c, p;
        logic     ring;
        verdict_t v;
        lon  = pt.lon;
        lat  = pt.lat;
        lo   = cfg_lat_low;
        hi   = cfg_lat_high;
        s    = cfg_lon_start;
        e    = cfg_lon_end;
        span = (s > e) ? s - e : e - s;
        ring = (span * 10 < UNIT);
        if (lon < 0) lon = lon + FULL;
        else if (lon >= FULL) lon = lon - FULL;

        if (lat < lo || lat > hi) v.in_region = 1'b0;
        else if (ring) v.in_region = 1'b1;
        else if (s > e) v.in_region = (lon >= s) || (lon <= e);
        else v.in_region = (lon >= s) && (lon <= e);

        best = HALF;
        // latitude margins count only for edges away from the poles
        if (1000 * (lo + QUARTER) > UNIT && lat - lo < best) best = lat - lo;
        if (1000 * (QUARTER - hi) > UNIT && hi - lat < best) best = hi - lat;

        if (!ring) begin
            alat = (lat < 0) ? -lat : lat;
            idx  = alat * (COS_TABLE_DEPTH - 1) / QUARTER;
            if (idx > COS_TABLE_DEPTH - 1) idx = COS_TABLE_DEPTH - 1;
            c = cos_q16[idx];
            p = (folded_gap(lon, s) * c) >>> 16;
            if (p < best) best = p;
            p = (folded_gap(lon, e) * c) >>> 16;
            if (p < best) best = p;
        end

        if (best > 65535) best = 65535;
        if (best < -65536) best = -65536;
        v.edge_dist = best[DIST_W-1:0];
        return v;
    endfunction

    function automatic point_t random_point();
        longint lon, lat, lo, hi;
        point_t pt;
        lo = cfg_lat_low;
        hi = cfg_lat_high;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: lon = longint'($urandom_range(0, 276479)) + LON_MIN;
            4, 5, 6: begin
                lon = $urandom_range(0, 1) ? cfg_lon_start : cfg_lon_end;
                lon = lon + longint'($urandom_range(0, 80)) - 40;
            end
            7: lon = longint'($urandom_range(0, 80)) - 40;
            8: lon = $urandom_range(0, 1) ? LON_MIN : LON_MAX;
            default: begin
                lon = cfg_lon_start;
                lon = lon + HALF + longint'($urandom_range(0, 80)) - 40;
            end
        endcase
        case ($urandom_range(0, 3))
            0: lon = lon + FULL;
            1: lon = lon - FULL;
            default: ;
        endcase
        if (lon < LON_MIN) lon = LON_MIN;
        if (lon > LON_MAX) lon = LON_MAX;

        case ($urandom_range(0, 7))
            0, 1, 2: lat = longint'($urandom_range(0, 46080)) - QUARTER;
            3, 4: begin
                if (lo <= hi) lat = lo + longint'($urandom_range(0, int'(hi - lo)));
                else lat = longint'($urandom_range(0, 46080)) - QUARTER;
            end
            5, 6: lat = ($urandom_range(0, 1) ? lo : hi) + longint'($urandom_range(0, 80)) - 40;
            default: begin
                case ($urandom_range(0, 2))
                    0: lat = -QUARTER;
                    1: lat = 0;
                    default: lat = QUARTER;
                endcase
            end
        endcase
        if (lat < -QUARTER) lat = -QUARTER;
        if (lat > QUARTER) lat = QUARTER;

        pt.lon = lon[LON_W-1:0];
        pt.lat = lat[LAT_W-1:0];
        return pt;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LON_START: cfg_lon_start = val[EDGE_W-1:0];
            REG_LON_END:   cfg_lon_end   = val[EDGE_W-1:0];
            REG_LAT_LOW:   cfg_lat_low   = val[LAT_W-1:0];
            REG_LAT_HIGH:  cfg_lat_high  = val[LAT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_region(int s, int e, int lo, int hi);
        write_reg(REG_LON_START, s);
        write_reg(REG_LON_END, e);
        write_reg(REG_LAT_LOW, lo);
        write_reg(REG_LAT_HIGH, hi);
    endtask

    task automatic wait_idle();
        while (pending_points.size() != 0 || s_valid || expected_verdicts.size() != 0)
            @(posedge aclk);
    endtask

    task automatic push_directed();
        point_t pt;
        for (int i = 0; i < N_DIR; i++) begin
            pt.lon = LON_W'(DIR_LON[i]);
            pt.lat = LAT_W'(DIR_LAT[i]);
            pending_points.push_back(pt);
        end
    endtask

    // sender
    always @(negedge aclk) begin
        point_t pt;
        logic   nv;
        if (aresetn) begin
            nv = s_valid;
            if (in_fire) nv = 1'b0;
            if (!nv) begin
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                end else if (pending_points.size() != 0) begin
                    pt = pending_points.pop_front();
                    s_point_lon <= pt.lon;
                    s_point_lat <= pt.lat;
                    nv = 1'b1;
                    in_gap = in_idle_on ? $urandom_range(0, 14) : 0;
                end
            end
            s_valid <= nv;
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (long_hold_req) begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (out_fire) out_gap = out_idle_on ? $urandom_range(0, 14) : 0;
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap = out_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        verdict_t want;
        point_t   pt;
        if (aresetn) begin
            cycles++;
            if (cycles > LIMIT) begin
                $display("timeout after %0d cycles", LIMIT);
                $display("FAIL sky_region_membership_border_distance");
                $finish;
            end else begin
                in_fire  = s_valid && s_ready;
                out_fire = m_valid && m_ready;
                if (out_fire) begin
                    if (expected_verdicts.size() == 0) begin
                        report_mismatch("beat with nothing expected, distance",
                                        m_edge_distance, 0);
                    end else begin
                        want = expected_verdicts.pop_front();
                        if (m_is_inside !== want.in_region)
                            report_mismatch("is_inside", m_is_inside, want.in_region);
                        if (m_edge_distance !== want.edge_dist)
                            report_mismatch("edge_distance", m_edge_distance,
                                            want.edge_dist);
                    end
                end
                if (in_fire) begin
                    pt.lon = s_point_lon;
                    pt.lat = s_point_lat;
                    expected_verdicts.push_back(region_verdict(pt));
                end
            end
        end
    end

    initial begin
        int s, e, lo, hi, t;
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_point_lon   = '0;
        s_point_lat   = '0;
        m_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cfg_lon_start = '0;
        cfg_lon_end   = '0;
        cfg_lat_low   = -16'sd23040;
        cfg_lat_high  = 16'sd23040;
        in_idle_on    = 1'b1;
        out_idle_on   = 1'b1;
        for (int i = 0; i < COS_TABLE_DEPTH; i++)
            cos_q16[i] = $rtoi($cos(3.14159265358979 * i / (2.0 * (COS_TABLE_DEPTH - 1)))
                              * 65535.0 + 0.5);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset region: full ring, both latitude edges at the poles
        push_directed();
        wait_idle();
        // span wrapping through zero, narrow band
        set_region(80000, 10000, -5000, 7000);
        push_directed();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            if (ph < N_FIXED) begin
                set_region(FIX_START[ph], FIX_END[ph], FIX_LO[ph], FIX_HI[ph]);
            end else begin
                s  = $urandom_range(0, 92159);
                e  = $urandom_range(0, 92159);
                lo = int'($urandom_range(0, 46080)) - QUARTER;
                hi = int'($urandom_range(0, 46080)) - QUARTER;
                if (lo > hi && $urandom_range(0, 3) != 0) begin
                    t  = lo;
                    lo = hi;
                    hi = t;
                end
                set_region(s, e, lo, hi);
            end
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            if (ph == 3) begin
                in_idle_on    = 1'b0;
                long_hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) pending_points.push_back(random_point());
        end

        wait_idle();
        repeat (16) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS sky_region_membership_border_distance");
        else
            $display("FAIL sky_region_membership_border_distance");
        $finish;
    end

endmodule
